>>> rtl/core/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types and constants of the box partition splitter: the input and
// result word layouts, operation and axis codes, and configuration indexes.
// ----------------------------------------------------------------------------
package bps_pkg;

  // coordinate and index widths fixed by the word formats
  localparam int COORD_W    = 20;
  localparam int SLOT_BITS  = 4;
  localparam int AXIS_W     = 2;
  localparam int ADDR_W     = AXIS_W + SLOT_BITS;
  localparam int NUM_AXES   = 3;
  localparam int SLOTS      = 1 << SLOT_BITS;
  localparam int MEM_DEPTH  = NUM_AXES * SLOTS;
  localparam int IN_LEN_W   = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 5;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PARTS_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PARTS_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PARTS_Z = 2'd2;

  typedef struct packed {
    logic                 op;
    logic [AXIS_W-1:0]    axis_sel;
    logic [SLOT_BITS-1:0] part_slot;
    logic [IN_LEN_W-1:0]  part_length;
    logic [COORD_W-1:0]   box_x_start;
    logic [COORD_W-1:0]   box_x_end;
    logic [COORD_W-1:0]   box_y_start;
    logic [COORD_W-1:0]   box_y_end;
    logic [COORD_W-1:0]   box_z_start;
    logic [COORD_W-1:0]   box_z_end;
  } in_word_t;

  typedef struct packed {
    logic [AXIS_W-1:0]    seg_axis;
    logic [COORD_W-1:0]   seg_start;
    logic [COORD_W-1:0]   seg_end;
    logic [SLOT_BITS-1:0] seg_part;
    logic [COORD_W-1:0]   offset_in_box;
    logic                 last;
    logic                 error;
  } out_word_t;

endpackage

>>> rtl/core/box_partition_splitter_top.sv
// ----------------------------------------------------------------------------
// box_partition_splitter_top
// Splits a queried box into per-part segments along x, y and z using part
// lengths held in a small length memory.
// ----------------------------------------------------------------------------
// A load word writes its part length into the length memory. A query word
// first walks the part lengths of all three axes through one shared adder,
// one length per cycle, to form the axis totals and check the box. It then
// walks the lengths again with the same adder, one part per cycle unless a
// touched part waits on a stalled output, and sends one result word per
// touched part, stopping on each axis at its last touched part; a rejected
// box gives a single error word instead. Both walks are bounded by the
// single read port of the length memory. The block takes no new word while
// a query is in progress. The length memory has no reset; a part must be
// loaded before a query uses it.
// ----------------------------------------------------------------------------
module box_partition_splitter_top #(
  parameter int MAX_PARTS = 16,
  parameter int LEN_BITS  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [bps_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [bps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bps_pkg::in_word_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bps_pkg::out_word_t                   out_data
);
  import bps_pkg::*;

  localparam int CNT_W = $clog2(MAX_PARTS + 1);
  localparam int SUM_W = LEN_BITS + SLOT_BITS;
  localparam int CMP_W = (SUM_W > COORD_W) ? SUM_W : COORD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_WALK, ST_ERR} state_t;

  // clamp a part count register to 1..MAX_PARTS
  function automatic logic [CNT_W-1:0] eff_parts(input logic [CFG_DATA_W-1:0] r);
    logic [CNT_W-1:0] n;
    if (r == '0) begin
      n = CNT_W'(1);
    end else if (r > CFG_DATA_W'(MAX_PARTS)) begin
      n = CNT_W'(MAX_PARTS);
    end else begin
      n = CNT_W'(r);
    end
    return n;
  endfunction

  state_t              state, state_next;
  logic [AXIS_W-1:0]   ax, ax_next;
  logic [CNT_W-1:0]    idx, idx_next;
  logic [SUM_W-1:0]    run, run_next;
  logic [COORD_W-1:0]  off, off_next;
  logic                bad, bad_next;
  logic                out_valid_next;
  out_word_t           out_next;
  in_word_t            box;

  logic [CFG_DATA_W-1:0] parts_x, parts_y, parts_z;

  logic [LEN_BITS-1:0] mem [0:MEM_DEPTH-1];
  logic [LEN_BITS-1:0] rdata;
  logic [ADDR_W-1:0]   rd_addr;

  logic [CNT_W-1:0]    n_ax;
  logic [COORD_W-1:0]  bs, be;
  logic [SUM_W-1:0]    sum;
  logic [CMP_W-1:0]    bs_c, be_c, lo_c, hi_c, seg_s, seg_e;
  logic                out_free, idx_end, hit, axis_end, box_bad;

  // axis view of the current query
  always_comb begin
    case (ax)
      AXIS_X: begin
        n_ax = eff_parts(parts_x);
        bs   = box.box_x_start;
        be   = box.box_x_end;
      end
      AXIS_Y: begin
        n_ax = eff_parts(parts_y);
        bs   = box.box_y_start;
        be   = box.box_y_end;
      end
      AXIS_Z: begin
        n_ax = eff_parts(parts_z);
        bs   = box.box_z_start;
        be   = box.box_z_end;
      end
      default: begin
        n_ax = CNT_W'(1);
        bs   = '0;
        be   = '0;
      end
    endcase
  end

  // shared adder: running total in the sum pass, upper boundary in the walk
  assign sum      = run + SUM_W'(rdata);
  assign bs_c     = CMP_W'(bs);
  assign be_c     = CMP_W'(be);
  assign lo_c     = CMP_W'(run);
  assign hi_c     = CMP_W'(sum);
  assign seg_s    = (bs_c > lo_c) ? bs_c : lo_c;
  assign seg_e    = (be_c < hi_c) ? be_c : hi_c;
  assign idx_end  = (CNT_W'(idx + 1'b1) == n_ax);
  assign hit      = (hi_c > bs_c) || (lo_c >= bs_c);
  assign axis_end = idx_end || (hi_c >= be_c);
  assign box_bad  = (bs_c >= be_c) || (be_c > hi_c);

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  // sequencer next state
  always_comb begin
    state_next     = state;
    ax_next        = ax;
    idx_next       = idx;
    run_next       = run;
    off_next       = off;
    bad_next       = bad;
    out_valid_next = out_valid && !out_ready;
    out_next       = out_data;
    case (state)
      ST_IDLE: begin
        if (in_valid && in_data.op == OP_QUERY) begin
          state_next = ST_SUM;
          ax_next    = AXIS_X;
          idx_next   = '0;
          run_next   = '0;
          bad_next   = 1'b0;
        end
      end
      ST_SUM: begin
        if (idx_end) begin
          bad_next = bad || box_bad;
          idx_next = '0;
          run_next = '0;
          if (ax == AXIS_Z) begin
            ax_next    = AXIS_X;
            off_next   = '0;
            state_next = (bad || box_bad) ? ST_ERR : ST_WALK;
          end else begin
            ax_next = ax + 1'b1;
          end
        end else begin
          idx_next = idx + 1'b1;
          run_next = sum;
        end
      end
      ST_WALK: begin
        if (!hit || out_free) begin
          if (hit) begin
            out_valid_next         = 1'b1;
            out_next.seg_axis      = ax;
            out_next.seg_start     = COORD_W'(seg_s);
            out_next.seg_end       = COORD_W'(seg_e);
            out_next.seg_part      = SLOT_BITS'(idx);
            out_next.offset_in_box = off;
            out_next.last          = (ax == AXIS_Z) && axis_end;
            out_next.error         = 1'b0;
          end
          if (axis_end) begin
            idx_next = '0;
            run_next = '0;
            off_next = '0;
            if (ax == AXIS_Z) begin
              ax_next    = AXIS_X;
              state_next = ST_IDLE;
            end else begin
              ax_next = ax + 1'b1;
            end
          end else begin
            idx_next = idx + 1'b1;
            run_next = sum;
            if (hit) begin
              off_next = off + COORD_W'(seg_e - seg_s);
            end
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_next         = 1'b1;
          out_next.seg_axis      = AXIS_X;
          out_next.seg_start     = '0;
          out_next.seg_end       = '0;
          out_next.seg_part      = '0;
          out_next.offset_in_box = '0;
          out_next.last          = 1'b1;
          out_next.error         = 1'b1;
          state_next             = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // read address follows the next walk position so rdata matches idx
  assign rd_addr = {ax_next, SLOT_BITS'(idx_next)};

  // length memory
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.op == OP_LOAD && in_data.axis_sel != AXIS_NONE) begin
      mem[{in_data.axis_sel, in_data.part_slot}] <= LEN_BITS'(in_data.part_length);
    end
    rdata <= mem[rd_addr];
  end

  // state, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ax        <= AXIS_X;
      idx       <= '0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
      parts_x   <= CFG_DATA_W'(1);
      parts_y   <= CFG_DATA_W'(1);
      parts_z   <= CFG_DATA_W'(1);
    end else begin
      state     <= state_next;
      ax        <= ax_next;
      idx       <= idx_next;
      bad       <= bad_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_PARTS_X: parts_x <= cfg_wdata;
          REG_PARTS_Y: parts_y <= cfg_wdata;
          REG_PARTS_Z: parts_z <= cfg_wdata;
          default: ;
        endcase
      end
    end
    run      <= run_next;
    off      <= off_next;
    out_data <= out_next;
    if (in_valid && in_ready && in_data.op == OP_QUERY) begin
      box <= in_data;
    end
  end

endmodule
